### rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types and constants for the texel shade and dither unit.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int FIX_W       = 32;  // 16.16 light word
  localparam int FRAC_W      = 16;
  localparam int TEXEL_W     = 8;
  localparam int START_W     = 20;
  localparam int IDX_W       = 13;
  localparam int VAL_W       = 16;
  localparam int PIX_W       = 16;
  localparam int BYTE_W      = 8;
  localparam int PAL_DEPTH   = 256;
  localparam int BLOCK_SHIFT = 9;   // 512 light-table entries per level
  localparam int HALF_BIT    = 8;   // selects the high-byte half of a block

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    FUNC_SHADE  = 2'd0,
    FUNC_PAL_WR = 2'd1,
    FUNC_LT_WR  = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_STEP = 1'b0,
    CFG_DITHER_EN  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic               take;
    logic               span_start;
    logic [START_W-1:0] start_light;
  } light_req_t;

endpackage

### rtl/lts_if.sv
// ----------------------------------------------------------------------------
// lts interfaces
// Valid/ready channels for shade items and shaded pixels.
// ----------------------------------------------------------------------------
interface lts_in_if import lts_pkg::*; ();
  logic               valid;
  logic               ready;
  func_t              func;
  logic [TEXEL_W-1:0] texel;
  logic               span_start;
  logic [START_W-1:0] start_light;
  logic [IDX_W-1:0]   table_index;
  logic [VAL_W-1:0]   table_value;

  modport source(output valid, func, texel, span_start, start_light, table_index,
                 table_value, input ready);
  modport sink(input valid, func, texel, span_start, start_light, table_index,
               table_value, output ready);
endinterface

interface lts_out_if import lts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source(output valid, pixel, input ready);
  modport sink(input valid, pixel, output ready);
endinterface

### rtl/lts_light_unit.sv
// ----------------------------------------------------------------------------
// lts_light_unit
// Light accumulator, dither error and clamped light level, plus config regs.
// ----------------------------------------------------------------------------
module lts_light_unit import lts_pkg::*; #(
  parameter int LIGHT_LEVELS = 16,
  parameter int LVL_W        = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  light_req_t            req,
  output logic [LVL_W-1:0]      level
);

  logic [FIX_W-1:0]  step_r;
  logic              dither_en_r;
  logic [FIX_W-1:0]  accum_r, accum_nxt;
  logic [FRAC_W-1:0] err_r, err_nxt;
  logic [FIX_W-1:0]  accum_cur;
  logic [FRAC_W-1:0] err_cur;
  logic [FIX_W-1:0]  sum;

  always_comb begin
    if (req.span_start) begin
      accum_cur = FIX_W'(req.start_light);
      err_cur   = '0;
    end else begin
      accum_cur = accum_r;
      err_cur   = err_r;
    end
    sum = accum_cur + FIX_W'(err_cur);
    // signed integer part, clamped to the table range
    priority if (sum[FIX_W-1]) begin
      level = '0;
    end else if (sum[FIX_W-2:FRAC_W] > (FIX_W-FRAC_W-1)'(LIGHT_LEVELS - 1)) begin
      level = LVL_W'(LIGHT_LEVELS - 1);
    end else begin
      level = LVL_W'(sum[FIX_W-2:FRAC_W]);
    end
    accum_nxt = accum_cur + step_r;
    err_nxt   = dither_en_r ? sum[FRAC_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      dither_en_r <= 1'b0;
      accum_r     <= '0;
      err_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LIGHT_STEP: step_r      <= cfg_data[FIX_W-1:0];
          CFG_DITHER_EN:  dither_en_r <= cfg_data[0];
        endcase
      end
      if (req.take) begin
        accum_r <= accum_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  a_no_dither_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    req.take && !dither_en_r |=> err_r == '0)
    else $error("dither error left non-zero with dither off");

  a_accum_step: assert property (@(posedge clk) disable iff (!rst_n)
    req.take && !req.span_start && !cfg_we |=> accum_r == $past(accum_r + step_r))
    else $error("accumulator did not advance by the step");

  a_span_load: assert property (@(posedge clk) disable iff (!rst_n)
    req.take && req.span_start && !cfg_we |=>
      accum_r == $past(FIX_W'(req.start_light) + step_r))
    else $error("span start did not load the accumulator");

endmodule

### rtl/lit_texel_shade_dither_unit.sv
// ----------------------------------------------------------------------------
// lit_texel_shade_dither_unit
// Palette lookup and light-table shading of 8-bit texels into 16-bit pixels.
// ----------------------------------------------------------------------------
// path: an input item is registered in stage 1, stage 2 and the output register in turn
// throughput: one item per cycle while the output is not stalled; the palette read and the two
//   light-table half reads each take one registered memory stage
// reset: synchronous, active low; clears pipeline valids, accumulator, error
//   and config; palette and light tables hold nothing until written
module lit_texel_shade_dither_unit import lts_pkg::*; #(
  parameter int LIGHT_LEVELS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lts_in_if.sink                in_ch,
  lts_out_if.source             out_ch
);

  localparam int LVL_W      = (LIGHT_LEVELS > 1) ? $clog2(LIGHT_LEVELS) : 1;
  localparam int LT_ADDR_W  = LVL_W + BYTE_W;
  localparam int LT_DEPTH   = LIGHT_LEVELS * PAL_DEPTH;
  localparam int LT_ENTRIES = LIGHT_LEVELS * (1 << BLOCK_SHIFT);

  logic in_xfer, s1_ready, s1_move, s2_ready, out_take;
  logic [LVL_W-1:0] level;
  light_req_t       light_req;

  // stage 1: palette read, light level
  logic             s1_valid_r;
  func_t            s1_func_r;
  logic [LVL_W-1:0] s1_level_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [VAL_W-1:0] s1_val_r;
  logic [VAL_W-1:0] s1_word_r;

  // stage 2: light-table halves
  logic             s2_valid_r;
  logic [VAL_W-1:0] lo_rd_r, hi_rd_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;

  logic [VAL_W-1:0] pal_mem [PAL_DEPTH];
  logic [VAL_W-1:0] lo_mem  [LT_DEPTH];
  logic [VAL_W-1:0] hi_mem  [LT_DEPTH];

  logic             lt_wr_ok;
  logic [LVL_W-1:0] wr_level;

  assign out_take = !out_valid_r || out_ch.ready;
  assign s2_ready = !s2_valid_r || out_take;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s1_move  = s1_valid_r && s2_ready;
  assign in_xfer  = in_ch.valid && s1_ready;

  assign in_ch.ready  = s1_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.pixel = out_pixel_r;

  assign light_req.take        = in_xfer && (in_ch.func == FUNC_SHADE);
  assign light_req.span_start  = in_ch.span_start;
  assign light_req.start_light = in_ch.start_light;

  lts_light_unit #(
    .LIGHT_LEVELS (LIGHT_LEVELS),
    .LVL_W        (LVL_W)
  ) u_light (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (light_req),
    .level     (level)
  );

  // palette: written and read in program order at the input transfer
  always_ff @(posedge clk) begin
    if (in_xfer && (in_ch.func == FUNC_PAL_WR) &&
        (in_ch.table_index < IDX_W'(PAL_DEPTH))) begin
      pal_mem[in_ch.table_index[BYTE_W-1:0]] <= in_ch.table_value;
    end
    if (in_xfer) begin
      s1_word_r <= pal_mem[in_ch.texel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_xfer && ((in_ch.func == FUNC_SHADE) || (in_ch.func == FUNC_LT_WR));
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r  <= in_ch.func;
      s1_level_r <= level;
      s1_idx_r   <= in_ch.table_index;
      s1_val_r   <= in_ch.table_value;
    end
  end

  assign lt_wr_ok = (32'(s1_idx_r) < 32'(LT_ENTRIES));
  assign wr_level = LVL_W'(s1_idx_r >> BLOCK_SHIFT);

  // light table split into low-byte and high-byte halves of each block
  always_ff @(posedge clk) begin
    if (s1_move && (s1_func_r == FUNC_LT_WR) && lt_wr_ok) begin
      if (s1_idx_r[HALF_BIT]) begin
        hi_mem[{wr_level, s1_idx_r[BYTE_W-1:0]}] <= s1_val_r;
      end else begin
        lo_mem[{wr_level, s1_idx_r[BYTE_W-1:0]}] <= s1_val_r;
      end
    end
    if (s1_move && (s1_func_r == FUNC_SHADE)) begin
      lo_rd_r <= lo_mem[LT_ADDR_W'({s1_level_r, s1_word_r[BYTE_W-1:0]})];
      hi_rd_r <= hi_mem[LT_ADDR_W'({s1_level_r, s1_word_r[VAL_W-1:BYTE_W]})];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= s1_move && (s1_func_r == FUNC_SHADE);
      end
      if (out_take) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s2_valid_r) begin
      out_pixel_r <= lo_rd_r + hi_rd_r;
    end
  end

  a_s1_kind: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_func_r == FUNC_SHADE || s1_func_r == FUNC_LT_WR))
    else $error("stage 1 holds an item that should have been dropped");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s2_ready |=> s2_valid_r && $stable(lo_rd_r) && $stable(hi_rd_r))
    else $error("stalled light-table data lost");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_ready |=> s1_valid_r && $stable(s1_word_r) && $stable(s1_level_r))
    else $error("stalled palette data lost");

  a_no_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && (s1_func_r == FUNC_LT_WR) |=> !s2_valid_r)
    else $error("table write produced a pixel");

endmodule

### tb/sv/lts_shade_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_shade_checker
// Watches the configuration port and both channels of the shade unit. Keeps
// its own copy of the light accumulator, dither carry, palette and light
// table, predicts each shaded pixel and compares it with the output in order.
// ----------------------------------------------------------------------------
module lts_shade_checker import lts_pkg::*; #(
  parameter int LEVELS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lts_in_if                     in_ch,
  lts_out_if                    out_ch,
  output int                    mismatches,
  output int                    pending
);

  localparam int LT_DEPTH   = LEVELS << BLOCK_SHIFT;
  localparam int MAX_REPORT = 10;

  logic [PIX_W-1:0]  pixel_q [$];
  logic [VAL_W-1:0]  palette [PAL_DEPTH];
  logic [VAL_W-1:0]  light_lut [LT_DEPTH];
  logic [FIX_W-1:0]  light;
  logic [FIX_W-1:0]  light_inc;
  logic [FRAC_W-1:0] carry;
  logic              dither_on;

  function automatic logic [PIX_W-1:0] shade_pixel(input logic [TEXEL_W-1:0] texel,
                                                   input logic               span_start,
                                                   input logic [START_W-1:0] start_light);
    logic [FIX_W-1:0]  lit_sum;
    logic [FRAC_W-1:0] lvl_word;
    logic [VAL_W-1:0]  word;
    logic [VAL_W-1:0]  lo;
    logic [VAL_W-1:0]  hi;
    int                lvl;
    int                base;
    if (span_start) begin
      light = FIX_W'(start_light);
      carry = '0;
    end
    lit_sum  = light + FIX_W'(carry);
    lvl_word = lit_sum[FIX_W-1 -: FRAC_W];
    // integer part read as signed, then clamped into the table
    if (lvl_word[FRAC_W-1]) begin
      lvl = 0;
    end else if (int'(lvl_word) > LEVELS - 1) begin
      lvl = LEVELS - 1;
    end else begin
      lvl = int'(lvl_word);
    end
    carry = dither_on ? carry + light[FRAC_W-1:0] : '0;
    light = light + light_inc;
    word  = palette[texel];
    base  = lvl << BLOCK_SHIFT;
    lo    = light_lut[base + int'(word[BYTE_W-1:0])];
    hi    = light_lut[base + (1 << HALF_BIT) + int'(word[VAL_W-1 -: BYTE_W])];
    return lo + hi;
  endfunction

  always @(posedge clk) begin
    logic [PIX_W-1:0] want;
    if (!rst_n) begin
      light      = '0;
      light_inc  = '0;
      carry      = '0;
      dither_on  = 1'b0;
      pixel_q.delete();
      mismatches <= 0;
      pending    <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LIGHT_STEP: light_inc = cfg_data;
          CFG_DITHER_EN:  dither_on = cfg_data[0];
          default: ;
        endcase
      end
      // compare before taking new transfers so no pixel can match its own item
      if (out_ch.valid && out_ch.ready) begin
        if (pixel_q.size() == 0) begin
          if (mismatches < MAX_REPORT) begin
            $display("%0t: unexpected pixel %04h", $time, out_ch.pixel);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = pixel_q.pop_front();
          if (out_ch.pixel !== want) begin
            if (mismatches < MAX_REPORT) begin
              $display("%0t: pixel mismatch, expected %04h, got %04h",
                       $time, want, out_ch.pixel);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.func)
          FUNC_SHADE: begin
            pixel_q.push_back(shade_pixel(in_ch.texel, in_ch.span_start, in_ch.start_light));
          end
          FUNC_PAL_WR: begin
            if (in_ch.table_index < PAL_DEPTH) begin
              palette[in_ch.table_index[TEXEL_W-1:0]] = in_ch.table_value;
            end
          end
          FUNC_LT_WR: begin
            if (in_ch.table_index < LT_DEPTH) begin
              light_lut[in_ch.table_index] = in_ch.table_value;
            end
          end
          default: ;
        endcase
      end
      pending <= pixel_q.size();
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the shade unit with table loads, directed shade items and random
// spans under several light step and dither settings, with random idling on
// both channels and one long output hold-off. The checker predicts every
// pixel; this module produces stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import lts_pkg::*;

  localparam int         LEVELS            = 16;
  localparam int         LT_DEPTH          = LEVELS << BLOCK_SHIFT;
  localparam logic [1:0] FUNC_UNUSED       = 2'd3;
  localparam int         ITEMS_PER_SETTING = 120;
  localparam int         NUM_SETTINGS      = 9;
  localparam int         PRESSURE_SETTING  = 6;
  localparam int         HOLD_CYCLES       = 300;
  localparam int         DRAIN_CYCLES      = 6;
  localparam int         QUIET_LIMIT       = 3000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_reqs;
  int holds_done;
  int quiet;
  int mismatches;
  int pending;

  // which texels and byte codes may be read without touching unwritten entries
  bit                 pal_written [PAL_DEPTH];
  bit                 byte_lit [2][1 << BYTE_W];
  logic [TEXEL_W-1:0] texel_pool [$];
  logic [BYTE_W-1:0]  lo_bytes [$];
  logic [BYTE_W-1:0]  hi_bytes [$];

  lts_in_if  in_ch ();
  lts_out_if out_ch ();

  lit_texel_shade_dither_unit #(.LIGHT_LEVELS(LEVELS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  lts_shade_checker #(.LEVELS(LEVELS)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // output side: random stalls plus the requested long hold-off
  initial begin
    int stall_left;
    stall_left   = 0;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (holds_done != hold_reqs) begin
        out_ch.ready <= 1'b0;
        stall_left = HOLD_CYCLES - 1;
        holds_done++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("** lit_texel_shade_dither_unit: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push(input logic [1:0] f, input logic [TEXEL_W-1:0] tx, input logic sp,
                      input logic [START_W-1:0] sl, input logic [IDX_W-1:0] idx,
                      input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= func_t'(f);
    in_ch.texel       <= tx;
    in_ch.span_start  <= sp;
    in_ch.start_light <= sl;
    in_ch.table_index <= idx;
    in_ch.table_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic shade(input logic [TEXEL_W-1:0] tx, input logic sp,
                       input logic [START_W-1:0] sl);
    push(FUNC_SHADE, tx, sp, sl, IDX_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic write_palette(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    push(FUNC_PAL_WR, TEXEL_W'($urandom), 1'($urandom), START_W'($urandom), idx, val);
    if (idx < PAL_DEPTH && !pal_written[idx[TEXEL_W-1:0]]) begin
      pal_written[idx[TEXEL_W-1:0]] = 1'b1;
      texel_pool.push_back(idx[TEXEL_W-1:0]);
    end
  endtask

  // load one byte code of one block half at every light level
  task automatic light_byte(input int half, input logic [BYTE_W-1:0] code);
    int lvl;
    if (byte_lit[half][code]) return;
    for (lvl = 0; lvl < LEVELS; lvl++) begin
      push(FUNC_LT_WR, TEXEL_W'($urandom), 1'($urandom), START_W'($urandom),
           IDX_W'((lvl << BLOCK_SHIFT) + (half << HALF_BIT) + code), VAL_W'($urandom));
    end
    byte_lit[half][code] = 1'b1;
    if (half == 0) lo_bytes.push_back(code);
    else hi_bytes.push_back(code);
  endtask

  function automatic logic [VAL_W-1:0] lit_word();
    return {hi_bytes[$urandom_range(hi_bytes.size() - 1)],
            lo_bytes[$urandom_range(lo_bytes.size() - 1)]};
  endfunction

  task automatic set_light(input logic [FIX_W-1:0] step, input logic dith);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LIGHT_STEP;
    cfg_data  <= step;
    @(posedge clk);
    cfg_index <= CFG_DITHER_EN;
    cfg_data  <= CFG_DATA_W'(dith);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int n);
    int   done;
    int   pick;
    int   len;
    int   k;
    logic span;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        len  = ($urandom_range(7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
        // now and then a span carries on from the previous accumulator
        span = ($urandom_range(9) != 0);
        for (k = 0; k < len; k++) begin
          shade(texel_pool[$urandom_range(texel_pool.size() - 1)], span && (k == 0),
                START_W'($urandom));
        end
        done += len;
      end else if (pick < 72) begin
        if ($urandom_range(5) == 0) begin
          write_palette(IDX_W'($urandom_range(PAL_DEPTH, (1 << IDX_W) - 1)), lit_word());
        end else begin
          write_palette(IDX_W'($urandom_range(PAL_DEPTH - 1)), lit_word());
          done++;
        end
      end else if (pick < 86) begin
        push(FUNC_LT_WR, TEXEL_W'($urandom), 1'($urandom), START_W'($urandom),
             IDX_W'($urandom_range(LT_DEPTH - 1)), VAL_W'($urandom));
        done++;
      end else if (pick < 93) begin
        // a new byte code costs one write per light level
        light_byte($urandom_range(1), BYTE_W'($urandom));
        done += LEVELS;
      end else begin
        push(FUNC_UNUSED, TEXEL_W'($urandom), 1'($urandom), START_W'($urandom),
             IDX_W'($urandom), VAL_W'($urandom));
      end
    end
  endtask

  initial begin
    int               s;
    logic [FIX_W-1:0] step;
    logic             dith;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_LIGHT_STEP;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_SHADE;
    in_ch.texel       = '0;
    in_ch.span_start  = 1'b0;
    in_ch.start_light = '0;
    in_ch.table_index = '0;
    in_ch.table_value = '0;
    tx_idle_pct       = 29;
    rx_idle_pct       = 47;
    hold_reqs         = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // eight levels per pixel with dither on
    set_light(32'h0008_0000, 1'b1);
    light_byte(0, 8'h00);
    light_byte(0, 8'hFF);
    light_byte(1, 8'h00);
    light_byte(1, 8'hFF);
    write_palette(13'd0, 16'h0000);
    write_palette(13'd255, 16'hFFFF);
    write_palette(13'h55, 16'h00FF);
    write_palette(13'hAA, 16'hFF00);

    shade(8'h00, 1'b1, 20'h00000);
    shade(8'hFF, 1'b1, 20'hFFFFF);
    // runs past the top level and clamps
    shade(8'h55, 1'b0, 20'h00000);
    shade(8'hAA, 1'b0, 20'hFFFFF);
    push(FUNC_UNUSED, 8'hFF, 1'b1, 20'hFFFFF, 13'h1FFF, 16'hFFFF);
    // palette writes beyond the palette are dropped
    write_palette(13'd256, 16'hFFFF);
    write_palette(13'h1FFF, 16'hFF00);
    // span start on a table write changes nothing
    push(FUNC_LT_WR, 8'hFF, 1'b1, 20'h00000, IDX_W'($urandom), VAL_W'($urandom));
    shade(8'h00, 1'b0, 20'hFFFFF);

    // most negative step: negative clamp, then wrap back around
    set_light(32'h8000_0000, 1'b0);
    shade(8'hFF, 1'b1, 20'h10000);
    shade(8'h00, 1'b0, 20'h00000);
    shade(8'hAA, 1'b0, 20'h00000);
    shade(8'h55, 1'b1, 20'h0FFFF);

    for (s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: begin step = 32'h0000_0000; dith = 1'b0; end
        1: begin step = 32'h0000_1000; dith = 1'b1; end
        2: begin step = 32'hFFFF_F000; dith = 1'b1; end
        3: begin step = 32'h7FFF_FFFF; dith = 1'b0; end
        4: begin step = 32'h8000_0000; dith = 1'b1; end
        5: begin step = $urandom;      dith = 1'($urandom); end
        6: begin step = 32'h0000_8000; dith = 1'b1; end
        7: begin step = 32'hFFFF_0000; dith = 1'b0; end
        default: begin
          step = FIX_W'(int'($urandom_range(32'h6_0000)) - 32'h3_0000);
          dith = 1'($urandom);
        end
      endcase
      set_light(step, dith);
      if (s < 3) begin
        tx_idle_pct = 29;
        rx_idle_pct <= 47;
      end else if (s < 6) begin
        tx_idle_pct = 47;
        rx_idle_pct <= 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (s == PRESSURE_SETTING) hold_reqs <= hold_reqs + 1;
      run_random(ITEMS_PER_SETTING);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** lit_texel_shade_dither_unit: PASSED **");
    end else begin
      $display("** lit_texel_shade_dither_unit: FAILED **");
    end
    $finish;
  end

endmodule
